### rtl/bpls_pkg.sv
// ----------------------------------------------------------------------------
// bpls_pkg: shared types and helpers of the load scheduler
// Slot states, opcodes, cell commands, search word and saturating arithmetic.
// ----------------------------------------------------------------------------
package bpls_pkg;

    localparam int SLOTS     = 16;
    localparam int COST_BITS = 48;
    localparam int SLOT_W    = 4;
    localparam int ORDER_W   = 32;
    localparam int CNT_W     = 5;
    localparam int CFG_W     = 48;
    localparam int SW_W      = $clog2(SLOTS + 2);
    localparam int LST_W     = $clog2(SLOTS + 1);

    localparam logic [COST_BITS-1:0] COST_MAX = '1;
    localparam logic [CNT_W-1:0]     BLK_MAX  = '1;

    typedef enum logic [2:0] {
        ST_EMPTY     = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_LOADING   = 3'd2,
        ST_RESIDENT  = 3'd3,
        ST_FAILED    = 3'd4,
        ST_CANCELLED = 3'd5
    } slot_state_t;

    typedef enum logic [2:0] {
        OP_QUEUE      = 3'd0,
        OP_SETPRIO    = 3'd1,
        OP_EVICT      = 3'd2,
        OP_COMPLETE   = 3'd3,
        OP_CANCEL     = 3'd4,
        OP_CANCEL_ALL = 3'd5,
        OP_TICK       = 3'd6,
        OP_QUERY      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        RK_ACCEPT  = 2'd0,
        RK_REJECT  = 2'd1,
        RK_STARTED = 2'd2,
        RK_SUMMARY = 2'd3
    } result_kind_t;

    localparam logic [1:0] OUT_LOADED    = 2'd0;
    localparam logic [1:0] OUT_CANCELLED = 2'd1;

    typedef enum logic [1:0] {
        CFG_MAX_LOADS = 2'd0,
        CFG_MAX_CPU   = 2'd1,
        CFG_MAX_VRAM  = 2'd2,
        CFG_MAX_IO    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_RESP, S_PREP, S_SWEEP, S_DECIDE, S_EMIT
    } seq_state_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_QUEUE,
        C_SETPRIO,
        C_EVICT,
        C_DONE,
        C_CANCEL,
        C_CANCEL_ALL,
        C_TICK_PREP,
        C_VISIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic [SLOT_W-1:0]    sel;
        logic [1:0]           prio;
        logic [ORDER_W-1:0]   order;
        logic [COST_BITS-1:0] cpu;
        logic [COST_BITS-1:0] vram;
        logic [COST_BITS-1:0] io;
        logic [1:0]           outcome;
        logic                 admit;
    } cell_cmd_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         prio;
        logic [ORDER_W-1:0] order;
        logic [SLOT_W-1:0]  idx;
    } best_t;

    function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                     input logic [COST_BITS-1:0] b);
        logic [COST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
    endfunction

    function automatic logic [COST_BITS-1:0] sat_sub(input logic [COST_BITS-1:0] a,
                                                     input logic [COST_BITS-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [COST_BITS-1:0] headroom(input logic [COST_BITS-1:0] lim,
                                                      input logic [COST_BITS-1:0] used);
        return (used < lim) ? (lim - used) : '0;
    endfunction

endpackage

### rtl/budgeted_priority_load_scheduler_unit.sv
// ----------------------------------------------------------------------------
// budgeted_priority_load_scheduler_unit: priority load admission under budgets
// Slot table as a row of cells; a sequencer runs events and admission ticks.
//
//   channel  | handshake              | words
//   ---------+------------------------+-------------------------------------
//   command  | start, busy            | op, slot, priority_req, costs, outcome
//   config   | cfg_we                 | cfg_index, cfg_data
//   result   | result_strobe          | result_kind .. queued_count
//
// A plain event passes through the execute and response states to a registered
// result; the next start is taken at the same edge that accepts the result.
// A tick runs a prep state, then a sweep and a decide state per visited
// queued slot and for the final empty search, then the emit state for each
// result word and the output register; the search ripples one cell per cycle.
// Reset empties all slots and clears totals; there is no clearing pass.
// The receiver cannot stall; each word is shown for one cycle.
// ----------------------------------------------------------------------------
module budgeted_priority_load_scheduler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     op,
    input  logic [bpls_pkg::SLOT_W-1:0]    slot,
    input  logic [1:0]                     priority_req,
    input  logic [bpls_pkg::COST_BITS-1:0] cpu_cost,
    input  logic [bpls_pkg::COST_BITS-1:0] vram_cost,
    input  logic [bpls_pkg::COST_BITS-1:0] io_cost,
    input  logic [1:0]                     outcome,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [bpls_pkg::CFG_W-1:0]     cfg_data,
    output logic                           result_strobe,
    output logic [1:0]                     result_kind,
    output logic [bpls_pkg::SLOT_W-1:0]    slot_res,
    output logic [2:0]                     slot_state,
    output logic                           last,
    output logic [bpls_pkg::COST_BITS-1:0] resident_cpu,
    output logic [bpls_pkg::COST_BITS-1:0] resident_vram,
    output logic [bpls_pkg::COST_BITS-1:0] reserved_cpu,
    output logic [bpls_pkg::COST_BITS-1:0] reserved_vram,
    output logic [bpls_pkg::COST_BITS-1:0] io_last_tick,
    output logic [bpls_pkg::CNT_W-1:0]     blocked_count,
    output logic [bpls_pkg::CNT_W-1:0]     loading_count,
    output logic [bpls_pkg::CNT_W-1:0]     queued_count
);

    localparam int CB = bpls_pkg::COST_BITS;

    bpls_pkg::seq_state_t state_reg, state_next;

    logic [bpls_pkg::CNT_W-1:0] mcl_reg, mcl_next;
    logic [CB-1:0] max_cpu_reg, max_cpu_next, max_vram_reg, max_vram_next;
    logic [CB-1:0] max_io_reg, max_io_next;

    logic [2:0]                  op_reg, op_next;
    logic [bpls_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [1:0]                  prio_reg, prio_next;
    logic [CB-1:0]               ccpu_reg, ccpu_next, cvram_reg, cvram_next;
    logic [CB-1:0]               cio_reg, cio_next;
    logic [1:0]                  outc_reg, outc_next;
    logic                        ok_reg, ok_next;

    logic [bpls_pkg::ORDER_W-1:0] arrival_reg, arrival_next;
    logic [CB-1:0] rcpu_reg, rcpu_next, rvram_reg, rvram_next;
    logic [CB-1:0] vcpu_reg, vcpu_next, vvram_reg, vvram_next;
    logic [CB-1:0] tio_reg, tio_next, iosch_reg, iosch_next;
    logic [bpls_pkg::CNT_W-1:0] tblk_reg, tblk_next, blk_reg, blk_next;
    logic [CB-1:0] ucpu_reg, ucpu_next, uvram_reg, uvram_next;
    logic [CB-1:0] hcpu_reg, hcpu_next, hvram_reg, hvram_next, hio_reg, hio_next;
    logic [bpls_pkg::SW_W-1:0]  cnt_reg, cnt_next;
    logic [bpls_pkg::LST_W-1:0] n_reg, n_next, rd_reg, rd_next;
    logic [bpls_pkg::SLOT_W-1:0] list_reg [bpls_pkg::SLOTS];
    logic                        list_we;

    logic        strobe_reg, strobe_next, last_reg, last_next;
    logic [1:0]  kind_reg, kind_next;
    logic [bpls_pkg::SLOT_W-1:0] sres_reg, sres_next;
    logic [2:0]  sst_reg, sst_next;

    bpls_pkg::cell_cmd_t   cmd;
    bpls_pkg::best_t       best_bus [bpls_pkg::SLOTS+1];
    bpls_pkg::slot_state_t st_bus   [bpls_pkg::SLOTS];
    logic [CB-1:0] cpu_bus [bpls_pkg::SLOTS];
    logic [CB-1:0] vram_bus [bpls_pkg::SLOTS];
    logic [CB-1:0] io_bus [bpls_pkg::SLOTS];

    logic [bpls_pkg::CNT_W-1:0] nload, nqueue, limit;
    bpls_pkg::best_t            best;
    bpls_pkg::slot_state_t      sel_st;
    logic                       in_range, admit;

    assign best_bus[0] = '0;

    for (genvar gi = 0; gi < bpls_pkg::SLOTS; gi++)
    begin : g_cell
        bpls_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (bpls_pkg::SLOT_W'(gi)),
            .cmd      (cmd),
            .best_in  (best_bus[gi]),
            .best_out (best_bus[gi+1]),
            .status   (st_bus[gi]),
            .cpu      (cpu_bus[gi]),
            .vram     (vram_bus[gi]),
            .io       (io_bus[gi])
        );
    end

    always_comb
    begin
        nload  = '0;
        nqueue = '0;
        for (int i = 0; i < bpls_pkg::SLOTS; i++)
        begin
            nload  = nload + bpls_pkg::CNT_W'(st_bus[i] == bpls_pkg::ST_LOADING);
            nqueue = nqueue + bpls_pkg::CNT_W'(st_bus[i] == bpls_pkg::ST_QUEUED);
        end
    end

    assign in_range = ({1'b0, slot_reg} < (bpls_pkg::SLOT_W+1)'(bpls_pkg::SLOTS));
    assign sel_st   = st_bus[slot_reg];
    assign best     = best_bus[bpls_pkg::SLOTS];
    assign limit    = (mcl_reg == '0) ? bpls_pkg::CNT_W'(1) : mcl_reg;
    assign admit    = (nload < limit) && (cpu_bus[best.idx] <= hcpu_reg) &&
                      (vram_bus[best.idx] <= hvram_reg) && (io_bus[best.idx] <= hio_reg);

    always_comb
    begin
        mcl_next     = mcl_reg;
        max_cpu_next = max_cpu_reg;
        max_vram_next = max_vram_reg;
        max_io_next  = max_io_reg;
        if (cfg_we)
        begin
            unique case (bpls_pkg::cfg_index_t'(cfg_index))
                bpls_pkg::CFG_MAX_LOADS: mcl_next      = cfg_data[bpls_pkg::CNT_W-1:0];
                bpls_pkg::CFG_MAX_CPU:   max_cpu_next  = cfg_data[CB-1:0];
                bpls_pkg::CFG_MAX_VRAM:  max_vram_next = cfg_data[CB-1:0];
                bpls_pkg::CFG_MAX_IO:    max_io_next   = cfg_data[CB-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        slot_next    = slot_reg;
        prio_next    = prio_reg;
        ccpu_next    = ccpu_reg;
        cvram_next   = cvram_reg;
        cio_next     = cio_reg;
        outc_next    = outc_reg;
        ok_next      = ok_reg;
        arrival_next = arrival_reg;
        rcpu_next    = rcpu_reg;
        rvram_next   = rvram_reg;
        vcpu_next    = vcpu_reg;
        vvram_next   = vvram_reg;
        tio_next     = tio_reg;
        iosch_next   = iosch_reg;
        tblk_next    = tblk_reg;
        blk_next     = blk_reg;
        ucpu_next    = ucpu_reg;
        uvram_next   = uvram_reg;
        hcpu_next    = hcpu_reg;
        hvram_next   = hvram_reg;
        hio_next     = hio_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        rd_next      = rd_reg;
        list_we      = 1'b0;
        strobe_next  = 1'b0;
        last_next    = last_reg;
        kind_next    = kind_reg;
        sres_next    = sres_reg;
        sst_next     = sst_reg;
        busy         = 1'b1;

        cmd          = '0;
        cmd.op       = bpls_pkg::C_NONE;
        cmd.sel      = slot_reg;
        cmd.prio     = prio_reg;
        cmd.order    = arrival_reg;
        cmd.cpu      = ccpu_reg;
        cmd.vram     = cvram_reg;
        cmd.io       = cio_reg;
        cmd.outcome  = outc_reg;

        unique case (state_reg)
            bpls_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    op_next    = op;
                    slot_next  = slot;
                    prio_next  = priority_req;
                    ccpu_next  = cpu_cost;
                    cvram_next = vram_cost;
                    cio_next   = io_cost;
                    outc_next  = outcome;
                    if (bpls_pkg::op_t'(op) == bpls_pkg::OP_TICK)
                        state_next = bpls_pkg::S_PREP;
                    else
                        state_next = bpls_pkg::S_EXEC;
                end
            end
            bpls_pkg::S_EXEC:
            begin
                ok_next    = 1'b0;
                state_next = bpls_pkg::S_RESP;
                priority case (bpls_pkg::op_t'(op_reg))
                    bpls_pkg::OP_QUERY:
                        ok_next = 1'b1;
                    bpls_pkg::OP_CANCEL_ALL:
                    begin
                        cmd.op  = bpls_pkg::C_CANCEL_ALL;
                        ok_next = 1'b1;
                    end
                    default:
                    begin
                        if (in_range)
                        begin
                            unique case (bpls_pkg::op_t'(op_reg))
                                bpls_pkg::OP_QUEUE:
                                begin
                                    cmd.op = bpls_pkg::C_QUEUE;
                                    if (sel_st == bpls_pkg::ST_EMPTY)
                                    begin
                                        ok_next      = 1'b1;
                                        arrival_next = arrival_reg + 1'b1;
                                    end
                                end
                                bpls_pkg::OP_SETPRIO:
                                begin
                                    cmd.op  = bpls_pkg::C_SETPRIO;
                                    ok_next = (sel_st == bpls_pkg::ST_QUEUED);
                                end
                                bpls_pkg::OP_EVICT:
                                begin
                                    cmd.op  = bpls_pkg::C_EVICT;
                                    ok_next = (sel_st != bpls_pkg::ST_EMPTY);
                                    if (sel_st == bpls_pkg::ST_LOADING)
                                    begin
                                        vcpu_next  = bpls_pkg::sat_sub(vcpu_reg,
                                                                       cpu_bus[slot_reg]);
                                        vvram_next = bpls_pkg::sat_sub(vvram_reg,
                                                                       vram_bus[slot_reg]);
                                    end
                                    else if (sel_st == bpls_pkg::ST_RESIDENT)
                                    begin
                                        rcpu_next  = bpls_pkg::sat_sub(rcpu_reg,
                                                                       cpu_bus[slot_reg]);
                                        rvram_next = bpls_pkg::sat_sub(rvram_reg,
                                                                       vram_bus[slot_reg]);
                                    end
                                end
                                bpls_pkg::OP_COMPLETE:
                                begin
                                    cmd.op = bpls_pkg::C_DONE;
                                    if (sel_st == bpls_pkg::ST_LOADING)
                                    begin
                                        ok_next    = 1'b1;
                                        vcpu_next  = bpls_pkg::sat_sub(vcpu_reg,
                                                                       cpu_bus[slot_reg]);
                                        vvram_next = bpls_pkg::sat_sub(vvram_reg,
                                                                       vram_bus[slot_reg]);
                                        if (outc_reg == bpls_pkg::OUT_LOADED)
                                        begin
                                            rcpu_next  = bpls_pkg::sat_add(rcpu_reg,
                                                                           cpu_bus[slot_reg]);
                                            rvram_next = bpls_pkg::sat_add(rvram_reg,
                                                                           vram_bus[slot_reg]);
                                        end
                                    end
                                end
                                default:
                                begin
                                    cmd.op  = bpls_pkg::C_CANCEL;
                                    ok_next = (sel_st != bpls_pkg::ST_EMPTY);
                                end
                            endcase
                        end
                    end
                endcase
            end
            bpls_pkg::S_RESP:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                state_next  = bpls_pkg::S_IDLE;
                if (bpls_pkg::op_t'(op_reg) == bpls_pkg::OP_QUERY)
                begin
                    kind_next = bpls_pkg::RK_SUMMARY;
                    sres_next = '0;
                    sst_next  = bpls_pkg::ST_EMPTY;
                end
                else if (bpls_pkg::op_t'(op_reg) == bpls_pkg::OP_CANCEL_ALL)
                begin
                    kind_next = bpls_pkg::RK_ACCEPT;
                    sres_next = '0;
                    sst_next  = bpls_pkg::ST_EMPTY;
                end
                else
                begin
                    kind_next = ok_reg ? bpls_pkg::RK_ACCEPT : bpls_pkg::RK_REJECT;
                    sres_next = slot_reg;
                    sst_next  = in_range ? sel_st : bpls_pkg::ST_EMPTY;
                end
            end
            bpls_pkg::S_PREP:
            begin
                cmd.op     = bpls_pkg::C_TICK_PREP;
                iosch_next = '0;
                blk_next   = '0;
                n_next     = '0;
                cnt_next   = '0;
                state_next = bpls_pkg::S_SWEEP;
            end
            bpls_pkg::S_SWEEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0)
                begin
                    ucpu_next  = bpls_pkg::sat_add(rcpu_reg, vcpu_reg);
                    uvram_next = bpls_pkg::sat_add(rvram_reg, vvram_reg);
                end
                else if (cnt_reg == bpls_pkg::SW_W'(1))
                begin
                    hcpu_next  = bpls_pkg::headroom(max_cpu_reg, ucpu_reg);
                    hvram_next = bpls_pkg::headroom(max_vram_reg, uvram_reg);
                    hio_next   = bpls_pkg::headroom(max_io_reg, iosch_reg);
                end
                if (cnt_reg == bpls_pkg::SW_W'(bpls_pkg::SLOTS))
                    state_next = bpls_pkg::S_DECIDE;
            end
            bpls_pkg::S_DECIDE:
            begin
                cnt_next = '0;
                if (!best.valid)
                begin
                    tio_next   = iosch_reg;
                    tblk_next  = blk_reg;
                    rd_next    = '0;
                    state_next = bpls_pkg::S_EMIT;
                end
                else
                begin
                    cmd.op     = bpls_pkg::C_VISIT;
                    cmd.sel    = best.idx;
                    cmd.admit  = admit;
                    state_next = bpls_pkg::S_SWEEP;
                    if (admit)
                    begin
                        vcpu_next  = bpls_pkg::sat_add(vcpu_reg, cpu_bus[best.idx]);
                        vvram_next = bpls_pkg::sat_add(vvram_reg, vram_bus[best.idx]);
                        iosch_next = bpls_pkg::sat_add(iosch_reg, io_bus[best.idx]);
                        list_we    = 1'b1;
                        n_next     = n_reg + 1'b1;
                    end
                    else if (blk_reg != bpls_pkg::BLK_MAX)
                    begin
                        blk_next = blk_reg + 1'b1;
                    end
                end
            end
            bpls_pkg::S_EMIT:
            begin
                strobe_next = 1'b1;
                if (rd_reg == n_reg)
                begin
                    kind_next  = bpls_pkg::RK_SUMMARY;
                    sres_next  = '0;
                    sst_next   = bpls_pkg::ST_EMPTY;
                    last_next  = 1'b1;
                    state_next = bpls_pkg::S_IDLE;
                end
                else
                begin
                    kind_next = bpls_pkg::RK_STARTED;
                    sres_next = list_reg[rd_reg[bpls_pkg::SLOT_W-1:0]];
                    sst_next  = bpls_pkg::ST_LOADING;
                    last_next = 1'b0;
                    rd_next   = rd_reg + 1'b1;
                end
            end
            default:
                state_next = bpls_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bpls_pkg::S_IDLE;
            mcl_reg     <= bpls_pkg::CNT_W'(1);
            max_cpu_reg <= '0;
            max_vram_reg <= '0;
            max_io_reg  <= '0;
            arrival_reg <= '0;
            rcpu_reg    <= '0;
            rvram_reg   <= '0;
            vcpu_reg    <= '0;
            vvram_reg   <= '0;
            tio_reg     <= '0;
            tblk_reg    <= '0;
            strobe_reg  <= 1'b0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            rd_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mcl_reg     <= mcl_next;
            max_cpu_reg <= max_cpu_next;
            max_vram_reg <= max_vram_next;
            max_io_reg  <= max_io_next;
            arrival_reg <= arrival_next;
            rcpu_reg    <= rcpu_next;
            rvram_reg   <= rvram_next;
            vcpu_reg    <= vcpu_next;
            vvram_reg   <= vvram_next;
            tio_reg     <= tio_next;
            tblk_reg    <= tblk_next;
            strobe_reg  <= strobe_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            rd_reg      <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        slot_reg  <= slot_next;
        prio_reg  <= prio_next;
        ccpu_reg  <= ccpu_next;
        cvram_reg <= cvram_next;
        cio_reg   <= cio_next;
        outc_reg  <= outc_next;
        ok_reg    <= ok_next;
        iosch_reg <= iosch_next;
        blk_reg   <= blk_next;
        ucpu_reg  <= ucpu_next;
        uvram_reg <= uvram_next;
        hcpu_reg  <= hcpu_next;
        hvram_reg <= hvram_next;
        hio_reg   <= hio_next;
        last_reg  <= last_next;
        kind_reg  <= kind_next;
        sres_reg  <= sres_next;
        sst_reg   <= sst_next;
        if (list_we)
            list_reg[n_reg[bpls_pkg::SLOT_W-1:0]] <= best.idx;
    end

    assign result_strobe = strobe_reg;
    assign result_kind   = kind_reg;
    assign slot_res      = sres_reg;
    assign slot_state    = sst_reg;
    assign last          = last_reg;
    assign resident_cpu  = rcpu_reg;
    assign resident_vram = rvram_reg;
    assign reserved_cpu  = vcpu_reg;
    assign reserved_vram = vvram_reg;
    assign io_last_tick  = tio_reg;
    assign blocked_count = tblk_reg;
    assign loading_count = nload;
    assign queued_count  = nqueue;

endmodule

### rtl/bpls_cell.sv
// ----------------------------------------------------------------------------
// bpls_cell: one slot of the scheduler table
// Holds one slot and passes the best queued candidate on to its neighbor.
// ----------------------------------------------------------------------------
module bpls_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bpls_pkg::SLOT_W-1:0]    idx,
    input  bpls_pkg::cell_cmd_t            cmd,
    input  bpls_pkg::best_t                best_in,
    output bpls_pkg::best_t                best_out,
    output bpls_pkg::slot_state_t          status,
    output logic [bpls_pkg::COST_BITS-1:0] cpu,
    output logic [bpls_pkg::COST_BITS-1:0] vram,
    output logic [bpls_pkg::COST_BITS-1:0] io
);

    bpls_pkg::slot_state_t            status_reg, status_next;
    logic                             cancel_reg, cancel_next;
    logic                             visited_reg, visited_next;
    logic [1:0]                       prio_reg, prio_next;
    logic [bpls_pkg::ORDER_W-1:0]     order_reg;
    logic [bpls_pkg::COST_BITS-1:0]   cpu_reg, vram_reg, io_reg;
    logic                             load;
    bpls_pkg::best_t                  best_reg, best_next, own;
    logic                             hit;
    logic                             own_better;

    assign hit = (cmd.sel == idx);

    always_comb
    begin
        status_next  = status_reg;
        cancel_next  = cancel_reg;
        visited_next = visited_reg;
        prio_next    = prio_reg;
        load         = 1'b0;
        unique case (cmd.op)
            bpls_pkg::C_QUEUE:
            begin
                if (hit && status_reg == bpls_pkg::ST_EMPTY)
                begin
                    status_next = bpls_pkg::ST_QUEUED;
                    cancel_next = 1'b0;
                    prio_next   = cmd.prio;
                    load        = 1'b1;
                end
            end
            bpls_pkg::C_SETPRIO:
            begin
                if (hit && status_reg == bpls_pkg::ST_QUEUED)
                    prio_next = cmd.prio;
            end
            bpls_pkg::C_EVICT:
            begin
                if (hit && status_reg != bpls_pkg::ST_EMPTY)
                begin
                    status_next = bpls_pkg::ST_EMPTY;
                    cancel_next = 1'b0;
                end
            end
            bpls_pkg::C_DONE:
            begin
                if (hit && status_reg == bpls_pkg::ST_LOADING)
                begin
                    if (cmd.outcome == bpls_pkg::OUT_LOADED)
                        status_next = bpls_pkg::ST_RESIDENT;
                    else if (cmd.outcome == bpls_pkg::OUT_CANCELLED)
                        status_next = bpls_pkg::ST_CANCELLED;
                    else
                        status_next = bpls_pkg::ST_FAILED;
                end
            end
            bpls_pkg::C_CANCEL:
            begin
                if (hit && status_reg != bpls_pkg::ST_EMPTY)
                    cancel_next = 1'b1;
            end
            bpls_pkg::C_CANCEL_ALL:
            begin
                if (status_reg != bpls_pkg::ST_EMPTY)
                    cancel_next = 1'b1;
            end
            bpls_pkg::C_TICK_PREP:
            begin
                visited_next = 1'b0;
                if (status_reg == bpls_pkg::ST_QUEUED && cancel_reg)
                    status_next = bpls_pkg::ST_CANCELLED;
            end
            bpls_pkg::C_VISIT:
            begin
                if (hit)
                begin
                    visited_next = 1'b1;
                    if (cmd.admit)
                        status_next = bpls_pkg::ST_LOADING;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        own.valid  = (status_reg == bpls_pkg::ST_QUEUED) && !visited_reg;
        own.prio   = prio_reg;
        own.order  = order_reg;
        own.idx    = idx;
        own_better = own.valid && (!best_in.valid || own.prio > best_in.prio ||
                     (own.prio == best_in.prio && own.order < best_in.order));
        best_next  = own_better ? own : best_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= bpls_pkg::ST_EMPTY;
            cancel_reg  <= 1'b0;
            visited_reg <= 1'b0;
            best_reg    <= '0;
        end
        else
        begin
            status_reg  <= status_next;
            cancel_reg  <= cancel_next;
            visited_reg <= visited_next;
            best_reg    <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        if (load)
        begin
            order_reg <= cmd.order;
            cpu_reg   <= cmd.cpu;
            vram_reg  <= cmd.vram;
            io_reg    <= cmd.io;
        end
    end

    assign best_out = best_reg;
    assign status   = status_reg;
    assign cpu      = cpu_reg;
    assign vram     = vram_reg;
    assign io       = io_reg;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the budgeted priority load scheduler
// Runs a directed table and then random, mostly well-formed command streams
// through several register settings. An in-bench model of the slot table
// predicts every result word, and a scoreboard checks each one as it arrives.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [47:0] MAX48  = '1;
    localparam int          WD_LIM = 5000;

    typedef struct {
        bpls_pkg::op_t op;
        logic [3:0]  slot;
        logic [1:0]  prio;
        logic [47:0] cpu;
        logic [47:0] vram;
        logic [47:0] io;
        logic [1:0]  outc;
        bit          has_exp;
        logic [1:0]  exp_kind;
        logic [2:0]  exp_state;
    } cmd_t;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [2:0]  state;
        logic        last;
        logic [47:0] res_cpu;
        logic [47:0] res_vram;
        logic [47:0] rsv_cpu;
        logic [47:0] rsv_vram;
        logic [47:0] io_tick;
        logic [4:0]  blocked;
        logic [4:0]  loading;
        logic [4:0]  queued;
    } word_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic [2:0]  op = 0;
    logic [3:0]  slot = 0;
    logic [1:0]  priority_req = 0;
    logic [47:0] cpu_cost = 0;
    logic [47:0] vram_cost = 0;
    logic [47:0] io_cost = 0;
    logic [1:0]  outcome = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [47:0] cfg_data = 0;
    logic        busy;
    logic        result_strobe;
    logic [1:0]  result_kind;
    logic [3:0]  slot_res;
    logic [2:0]  slot_state;
    logic        last;
    logic [47:0] resident_cpu, resident_vram, reserved_cpu, reserved_vram, io_last_tick;
    logic [4:0]  blocked_count, loading_count, queued_count;

    budgeted_priority_load_scheduler_unit u_top (.*);

    always #1 clk = ~clk;

    // slot table model
    bpls_pkg::slot_state_t sl_state [16];
    bit           sl_cancel[16];
    logic [1:0]   sl_prio  [16];
    logic [31:0]  sl_order [16];
    logic [47:0]  sl_cpu [16], sl_vram[16], sl_io[16];
    logic [31:0]  arrivals;
    logic [47:0]  tot_res_cpu, tot_res_vram, tot_rsv_cpu, tot_rsv_vram, tick_io;
    logic [4:0]   tick_blocked;
    logic [4:0]   lim_loads;
    logic [47:0]  lim_cpu, lim_vram, lim_io;

    word_t        pending_words[$];
    cmd_t         script[$];
    cmd_t         cur;
    int           errs = 0;
    int           n_items = 0, n_words = 0, n_starts = 0, n_ticks = 0;
    int           idle_pct = 0;
    int           wd = 0;

    task automatic put_word(word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic add_row(cmd_t r);
        script.insert(script.size(), r);
    endtask

    function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? MAX48 : s[47:0];
    endfunction

    function automatic logic [47:0] sub_sat(logic [47:0] a, logic [47:0] b);
        return (a > b) ? a - b : 48'd0;
    endfunction

    function automatic logic [47:0] room(logic [47:0] lim, logic [47:0] used);
        return (used < lim) ? lim - used : 48'd0;
    endfunction

    function automatic logic [4:0] count_in(bpls_pkg::slot_state_t st);
        logic [4:0] n;
        n = 0;
        for (int i = 0; i < 16; i++)
            if (sl_state[i] == st)
                n++;
        return n;
    endfunction

    function automatic word_t snap(logic [1:0] k, logic [3:0] s, logic [2:0] st, logic l);
        word_t w;
        w.kind = k; w.slot = s; w.state = st; w.last = l;
        w.res_cpu = tot_res_cpu; w.res_vram = tot_res_vram;
        w.rsv_cpu = tot_rsv_cpu; w.rsv_vram = tot_rsv_vram;
        w.io_tick = tick_io; w.blocked = tick_blocked;
        w.loading = count_in(bpls_pkg::ST_LOADING);
        w.queued = count_in(bpls_pkg::ST_QUEUED);
        return w;
    endfunction

    task automatic model_reset();
        for (int i = 0; i < 16; i++)
        begin
            sl_state[i] = bpls_pkg::ST_EMPTY; sl_cancel[i] = 0; sl_prio[i] = 0;
            sl_order[i] = 0; sl_cpu[i] = 0; sl_vram[i] = 0; sl_io[i] = 0;
        end
        arrivals = 0;
        tot_res_cpu = 0; tot_res_vram = 0; tot_rsv_cpu = 0; tot_rsv_vram = 0;
        tick_io = 0; tick_blocked = 0;
        lim_loads = 1; lim_cpu = 0; lim_vram = 0; lim_io = 0;
    endtask

    task automatic schedule_cmd(cmd_t c);
        bit          ok;
        int          best;
        logic [3:0]  started[$];
        logic [4:0]  active, lim;
        logic [47:0] io_sched;
        logic [15:0] seen;
        logic [4:0]  blk;
        bpls_pkg::slot_state_t st;
        word_t       w;
        ok = 0;
        n_items++;
        if (c.op == bpls_pkg::OP_TICK)
        begin
            n_ticks++;
            active = count_in(bpls_pkg::ST_LOADING);
            lim = (lim_loads == 0) ? 5'd1 : lim_loads;
            io_sched = 0; seen = 0; blk = 0;
            for (int i = 0; i < 16; i++)
                if (sl_state[i] == bpls_pkg::ST_QUEUED && sl_cancel[i])
                    sl_state[i] = bpls_pkg::ST_CANCELLED;
            forever
            begin
                best = -1;
                for (int i = 0; i < 16; i++)
                begin
                    if (sl_state[i] != bpls_pkg::ST_QUEUED || seen[i])
                        continue;
                    if (best < 0 || sl_prio[i] > sl_prio[best] ||
                        (sl_prio[i] == sl_prio[best] && sl_order[i] < sl_order[best]))
                        best = i;
                end
                if (best < 0)
                    break;
                seen[best] = 1;
                if (active >= lim ||
                    sl_cpu[best] > room(lim_cpu, add_sat(tot_res_cpu, tot_rsv_cpu)) ||
                    sl_vram[best] > room(lim_vram, add_sat(tot_res_vram, tot_rsv_vram)) ||
                    sl_io[best] > room(lim_io, io_sched))
                begin
                    if (blk < 31)
                        blk++;
                    continue;
                end
                sl_state[best] = bpls_pkg::ST_LOADING;
                tot_rsv_cpu = add_sat(tot_rsv_cpu, sl_cpu[best]);
                tot_rsv_vram = add_sat(tot_rsv_vram, sl_vram[best]);
                io_sched = add_sat(io_sched, sl_io[best]);
                active++;
                started.insert(started.size(), 4'(best));
            end
            tick_io = io_sched;
            tick_blocked = blk;
            n_starts += started.size();
            foreach (started[k])
                put_word(snap(bpls_pkg::RK_STARTED, started[k], bpls_pkg::ST_LOADING, 0));
            put_word(snap(bpls_pkg::RK_SUMMARY, 0, 0, 1));
            return;
        end
        if (c.op == bpls_pkg::OP_QUERY || c.op == bpls_pkg::OP_CANCEL_ALL)
        begin
            if (c.op == bpls_pkg::OP_CANCEL_ALL)
                for (int i = 0; i < 16; i++)
                    if (sl_state[i] != bpls_pkg::ST_EMPTY)
                        sl_cancel[i] = 1;
            w = snap(c.op == bpls_pkg::OP_QUERY ? bpls_pkg::RK_SUMMARY : bpls_pkg::RK_ACCEPT,
                     0, 0, 1);
        end
        else
        begin
            st = sl_state[c.slot];
            case (c.op)
                bpls_pkg::OP_QUEUE:
                    if (st == bpls_pkg::ST_EMPTY)
                    begin
                        sl_state[c.slot] = bpls_pkg::ST_QUEUED; sl_cancel[c.slot] = 0;
                        sl_prio[c.slot] = c.prio; sl_order[c.slot] = arrivals++;
                        sl_cpu[c.slot] = c.cpu; sl_vram[c.slot] = c.vram;
                        sl_io[c.slot] = c.io;
                        ok = 1;
                    end
                bpls_pkg::OP_SETPRIO:
                    if (st == bpls_pkg::ST_QUEUED)
                    begin
                        sl_prio[c.slot] = c.prio;
                        ok = 1;
                    end
                bpls_pkg::OP_EVICT:
                    if (st != bpls_pkg::ST_EMPTY)
                    begin
                        if (st == bpls_pkg::ST_LOADING)
                        begin
                            tot_rsv_cpu = sub_sat(tot_rsv_cpu, sl_cpu[c.slot]);
                            tot_rsv_vram = sub_sat(tot_rsv_vram, sl_vram[c.slot]);
                        end
                        else if (st == bpls_pkg::ST_RESIDENT)
                        begin
                            tot_res_cpu = sub_sat(tot_res_cpu, sl_cpu[c.slot]);
                            tot_res_vram = sub_sat(tot_res_vram, sl_vram[c.slot]);
                        end
                        sl_state[c.slot] = bpls_pkg::ST_EMPTY; sl_cancel[c.slot] = 0;
                        ok = 1;
                    end
                bpls_pkg::OP_COMPLETE:
                    if (st == bpls_pkg::ST_LOADING)
                    begin
                        tot_rsv_cpu = sub_sat(tot_rsv_cpu, sl_cpu[c.slot]);
                        tot_rsv_vram = sub_sat(tot_rsv_vram, sl_vram[c.slot]);
                        if (c.outc == bpls_pkg::OUT_LOADED)
                        begin
                            tot_res_cpu = add_sat(tot_res_cpu, sl_cpu[c.slot]);
                            tot_res_vram = add_sat(tot_res_vram, sl_vram[c.slot]);
                            sl_state[c.slot] = bpls_pkg::ST_RESIDENT;
                        end
                        else if (c.outc == bpls_pkg::OUT_CANCELLED)
                            sl_state[c.slot] = bpls_pkg::ST_CANCELLED;
                        else
                            sl_state[c.slot] = bpls_pkg::ST_FAILED;
                        ok = 1;
                    end
                default:
                    if (st != bpls_pkg::ST_EMPTY)
                    begin
                        sl_cancel[c.slot] = 1;
                        ok = 1;
                    end
            endcase
            w = snap(ok ? bpls_pkg::RK_ACCEPT : bpls_pkg::RK_REJECT, c.slot,
                     sl_state[c.slot], 1);
        end
        if (c.has_exp)
        begin
            w.kind = c.exp_kind;
            w.state = c.exp_state;
        end
        put_word(w);
    endtask

    task automatic mismatch(string what, logic [47:0] got, logic [47:0] want);
        errs++;
        $display("error: word %0d %s got %0h want %0h", n_words, what, got, want);
    endtask

    always @(posedge clk)
    begin
        bit    moved;
        word_t e;
        if (rst_n)
        begin
            moved = 0;
            if (cfg_we)
                case (cfg_index)
                    bpls_pkg::CFG_MAX_LOADS: lim_loads = cfg_data[4:0];
                    bpls_pkg::CFG_MAX_CPU:   lim_cpu = cfg_data;
                    bpls_pkg::CFG_MAX_VRAM:  lim_vram = cfg_data;
                    default:                 lim_io = cfg_data;
                endcase
            if (start && !busy)
            begin
                schedule_cmd(cur);
                moved = 1;
            end
            if (result_strobe)
            begin
                moved = 1;
                n_words++;
                if (pending_words.size() == 0)
                    mismatch("unexpected", 48'(result_kind), 48'd0);
                else
                begin
                    e = pending_words.pop_front();
                    if (result_kind !== e.kind)
                        mismatch("result_kind", 48'(result_kind), 48'(e.kind));
                    if (slot_res !== e.slot)
                        mismatch("slot_res", 48'(slot_res), 48'(e.slot));
                    if (slot_state !== e.state)
                        mismatch("slot_state", 48'(slot_state), 48'(e.state));
                    if (last !== e.last)
                        mismatch("last", 48'(last), 48'(e.last));
                    if (resident_cpu !== e.res_cpu)
                        mismatch("resident_cpu", resident_cpu, e.res_cpu);
                    if (resident_vram !== e.res_vram)
                        mismatch("resident_vram", resident_vram, e.res_vram);
                    if (reserved_cpu !== e.rsv_cpu)
                        mismatch("reserved_cpu", reserved_cpu, e.rsv_cpu);
                    if (reserved_vram !== e.rsv_vram)
                        mismatch("reserved_vram", reserved_vram, e.rsv_vram);
                    if (io_last_tick !== e.io_tick)
                        mismatch("io_last_tick", io_last_tick, e.io_tick);
                    if (blocked_count !== e.blocked)
                        mismatch("blocked_count", 48'(blocked_count), 48'(e.blocked));
                    if (loading_count !== e.loading)
                        mismatch("loading_count", 48'(loading_count), 48'(e.loading));
                    if (queued_count !== e.queued)
                        mismatch("queued_count", 48'(queued_count), 48'(e.queued));
                end
            end
            wd <= moved ? 0 : wd + 1;
            if (wd >= WD_LIM)
            begin
                $display("error: no progress for %0d cycles", WD_LIM);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic issue(cmd_t c);
        bit taken;
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 0;
        end
        @(negedge clk);
        cur = c;
        op <= c.op; slot <= c.slot; priority_req <= c.prio;
        cpu_cost <= c.cpu; vram_cost <= c.vram; io_cost <= c.io; outcome <= c.outc;
        start <= 1;
        taken = 0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
    endtask

    // hold the command port until every word has come, then let the block settle
    task automatic drain();
        @(negedge clk);
        start <= 0;
        while (pending_words.size() != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_limits(logic [4:0] loads, logic [47:0] c, logic [47:0] v,
                              logic [47:0] io_lim);
        drain();
        cfg_we <= 1; cfg_index <= bpls_pkg::CFG_MAX_LOADS; cfg_data <= {43'd0, loads};
        @(negedge clk);
        cfg_index <= bpls_pkg::CFG_MAX_CPU; cfg_data <= c;
        @(negedge clk);
        cfg_index <= bpls_pkg::CFG_MAX_VRAM; cfg_data <= v;
        @(negedge clk);
        cfg_index <= bpls_pkg::CFG_MAX_IO; cfg_data <= io_lim;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [47:0] pick_cost();
        int m;
        m = $urandom_range(0, 9);
        if (m == 0) return 48'd0;
        if (m == 1) return MAX48;
        if (m <= 3) return 48'({$urandom, $urandom});
        return 48'($urandom_range(0, 4000));
    endfunction

    function automatic cmd_t mk(bpls_pkg::op_t o, logic [3:0] s, logic [1:0] p,
                                logic [47:0] c, logic [47:0] v, logic [47:0] i,
                                logic [1:0] oc);
        cmd_t r;
        r.op = o; r.slot = s; r.prio = p; r.cpu = c; r.vram = v; r.io = i; r.outc = oc;
        r.has_exp = 0; r.exp_kind = 0; r.exp_state = 0;
        return r;
    endfunction

    function automatic cmd_t mkx(cmd_t r, logic [1:0] k, logic [2:0] st);
        r.has_exp = 1; r.exp_kind = k; r.exp_state = st;
        return r;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t       c;
        int         m, pool[$];
        bpls_pkg::slot_state_t want;
        m = $urandom_range(0, 99);
        c = mk(bpls_pkg::OP_QUERY, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
               pick_cost(), pick_cost(), pick_cost(), 2'($urandom_range(0, 3)));
        want = bpls_pkg::ST_EMPTY;
        if (m < 32) begin c.op = bpls_pkg::OP_QUEUE; want = bpls_pkg::ST_EMPTY; end
        else if (m < 52) c.op = bpls_pkg::OP_TICK;
        else if (m < 68) begin c.op = bpls_pkg::OP_COMPLETE; want = bpls_pkg::ST_LOADING; end
        else if (m < 78) begin c.op = bpls_pkg::OP_EVICT; want = bpls_pkg::ST_RESIDENT; end
        else if (m < 85) begin c.op = bpls_pkg::OP_SETPRIO; want = bpls_pkg::ST_QUEUED; end
        else if (m < 92) begin c.op = bpls_pkg::OP_CANCEL; want = bpls_pkg::ST_QUEUED; end
        else if (m < 95) c.op = bpls_pkg::OP_CANCEL_ALL;
        if (c.op inside {bpls_pkg::OP_QUEUE, bpls_pkg::OP_COMPLETE, bpls_pkg::OP_EVICT,
                         bpls_pkg::OP_SETPRIO, bpls_pkg::OP_CANCEL} &&
            $urandom_range(0, 99) < 85)
        begin
            for (int i = 0; i < 16; i++)
                if (sl_state[i] == want ||
                    (c.op == bpls_pkg::OP_EVICT && sl_state[i] != bpls_pkg::ST_EMPTY))
                    pool.insert(pool.size(), i);
            if (pool.size() != 0)
                c.slot = 4'(pool[$urandom_range(0, pool.size() - 1)]);
        end
        return c;
    endfunction

    initial
    begin
        model_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        add_row(mkx(mk(bpls_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0),
                    bpls_pkg::RK_SUMMARY, bpls_pkg::ST_EMPTY));
        add_row(mkx(mk(bpls_pkg::OP_SETPRIO, 0, 3, 0, 0, 0, 0),
                    bpls_pkg::RK_REJECT, bpls_pkg::ST_EMPTY));
        add_row(mkx(mk(bpls_pkg::OP_EVICT, 1, 0, 0, 0, 0, 0),
                    bpls_pkg::RK_REJECT, bpls_pkg::ST_EMPTY));
        add_row(mkx(mk(bpls_pkg::OP_COMPLETE, 2, 0, 0, 0, 0, 0),
                    bpls_pkg::RK_REJECT, bpls_pkg::ST_EMPTY));
        add_row(mkx(mk(bpls_pkg::OP_CANCEL, 3, 0, 0, 0, 0, 0),
                    bpls_pkg::RK_REJECT, bpls_pkg::ST_EMPTY));
        add_row(mkx(mk(bpls_pkg::OP_CANCEL_ALL, 0, 0, 0, 0, 0, 0),
                    bpls_pkg::RK_ACCEPT, bpls_pkg::ST_EMPTY));
        add_row(mkx(mk(bpls_pkg::OP_QUEUE, 0, 3, 0, 0, 0, 0),
                    bpls_pkg::RK_ACCEPT, bpls_pkg::ST_QUEUED));
        add_row(mkx(mk(bpls_pkg::OP_QUEUE, 0, 1, 5, 5, 5, 0),
                    bpls_pkg::RK_REJECT, bpls_pkg::ST_QUEUED));
        add_row(mkx(mk(bpls_pkg::OP_QUEUE, 15, 0, MAX48, MAX48, MAX48, 0),
                    bpls_pkg::RK_ACCEPT, bpls_pkg::ST_QUEUED));
        add_row(mk(bpls_pkg::OP_QUEUE, 5, 1, 0, 0, 0, 0));
        add_row(mk(bpls_pkg::OP_SETPRIO, 5, 2, 0, 0, 0, 0));
        add_row(mk(bpls_pkg::OP_QUEUE, 7, 2, 0, 0, 0, 0));
        add_row(mk(bpls_pkg::OP_CANCEL, 7, 0, 0, 0, 0, 0));
        add_row(mk(bpls_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        add_row(mk(bpls_pkg::OP_COMPLETE, 0, 0, 0, 0, 0, bpls_pkg::OUT_LOADED));
        add_row(mk(bpls_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        add_row(mk(bpls_pkg::OP_COMPLETE, 5, 0, 0, 0, 0, 2'd3));
        add_row(mk(bpls_pkg::OP_COMPLETE, 15, 0, 0, 0, 0, bpls_pkg::OUT_CANCELLED));
        add_row(mk(bpls_pkg::OP_EVICT, 0, 0, 0, 0, 0, 0));
        add_row(mk(bpls_pkg::OP_EVICT, 7, 0, 0, 0, 0, 0));
        add_row(mk(bpls_pkg::OP_EVICT, 15, 0, 0, 0, 0, 0));
        add_row(mk(bpls_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0));
        foreach (script[k])
            issue(script[k]);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_limits(5'd16, MAX48, MAX48, MAX48);
                1: set_limits(5'd2, 48'd6000, 48'd5000, 48'd3000);
                2: set_limits(5'd0, 48'd20000, MAX48, MAX48);
                default: set_limits(5'd31, MAX48, 48'd0, 48'({$urandom, $urandom}));
            endcase
            idle_pct = (ph == 0) ? 27 : (ph == 1) ? 48 : 0;
            for (int k = 0; k < 25; k++)
                issue(rand_cmd());
        end

        drain();
        repeat (20) @(negedge clk);
        $display("covered %0d commands, %0d ticks, %0d loads started, %0d words checked",
                 n_items, n_ticks, n_starts, n_words);
        $display("register settings: reset values plus four phases incl. zero and full limits");
        if (errs == 0 && pending_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
